/* src/utp_pkg.sv */
// ----------------------------------------------------------------------------
// utp_pkg
// Shared types, constants and the code point mapping of the UTF-8 to panel
// charset converter.
// ----------------------------------------------------------------------------
package utp_pkg;

  localparam int OUT_CAPACITY = 64;
  localparam int CNT_W        = $clog2(OUT_CAPACITY);
  localparam int MAX_ITEMS    = 3;
  localparam int FIFO_DEPTH   = 4;
  localparam int PTR_W        = $clog2(FIFO_DEPTH);
  localparam int FCNT_W       = $clog2(FIFO_DEPTH + 1);

  localparam logic [31:0] CP_MAX     = 32'h0010_FFFF;
  localparam logic [31:0] CP_LATIN   = 32'h0000_00FF;
  localparam logic [31:0] CP_CYR_LO  = 32'h0000_0400;
  localparam logic [7:0]  CYR_OFFSET = 8'h60;  // low byte of 0x360
  localparam logic [7:0]  CASE_DIFF  = 8'h20;

  typedef struct packed {
    logic [7:0] ch;
    logic       term;
  } utp_item_t;

  typedef struct packed {
    logic [1:0]                    n;
    utp_item_t [MAX_ITEMS-1:0]     item;
  } utp_items_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] ch;
  } utp_pt_t;

  function automatic utp_pt_t map_point(logic [31:0] cp, logic upcase);
    utp_pt_t r;
    r.ok = 1'b0;
    r.ch = cp[7:0];
    if (cp <= CP_MAX) begin
      if (cp <= CP_LATIN) begin
        r.ok = 1'b1;
        if (upcase && cp[7:0] >= 8'h61 && cp[7:0] <= 8'h7A) begin
          r.ch = cp[7:0] - CASE_DIFF;
        end
      end else if (cp >= CP_CYR_LO) begin
        r.ok = 1'b1;
        r.ch = cp[7:0] - CYR_OFFSET;
      end
    end
    return r;
  endfunction

endpackage

/* src/utp_decode.sv */
// ----------------------------------------------------------------------------
// utp_decode
// Holds the code point being assembled and the per-string character count;
// turns one accepted byte into up to three result items.
// ----------------------------------------------------------------------------
module utp_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  input  logic              upcase_i,
  output utp_pkg::utp_items_t items_o
);
  import utp_pkg::*;

  logic [31:0]      accum_q, accum_d;
  logic             pend_q, pend_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic             cont;
  utp_pt_t          p1, p2;
  logic             e1, e2;
  logic [CNT_W-1:0] cnt_mid;
  logic [1:0]       idx;

  always_comb begin
    cont = (byte_i[7:6] == 2'b10);
    if (byte_i <= 8'h7F) begin
      accum_d = {24'd0, byte_i};
    end else if (byte_i <= 8'hBF) begin
      accum_d = {accum_q[25:0], byte_i[5:0]};
    end else if (byte_i <= 8'hDF) begin
      accum_d = {27'd0, byte_i[4:0]};
    end else if (byte_i <= 8'hEF) begin
      accum_d = {28'd0, byte_i[3:0]};
    end else begin
      accum_d = {29'd0, byte_i[2:0]};
    end

    p1 = map_point(accum_q, upcase_i);
    p2 = map_point(accum_d, upcase_i);
    e1 = pend_q && !cont && p1.ok && (cnt_q < CNT_W'(OUT_CAPACITY - 1));
    cnt_mid = cnt_q + CNT_W'(e1);
    e2 = last_i && p2.ok && (cnt_mid < CNT_W'(OUT_CAPACITY - 1));

    items_o = '0;
    idx = 2'd0;
    if (e1) begin
      items_o.item[idx] = '{ch: p1.ch, term: 1'b0};
      idx = idx + 2'd1;
    end
    if (e2) begin
      items_o.item[idx] = '{ch: p2.ch, term: 1'b0};
      idx = idx + 2'd1;
    end
    if (last_i) begin
      items_o.item[idx] = '{ch: 8'd0, term: 1'b1};
      idx = idx + 2'd1;
    end
    items_o.n = fire_i ? idx : 2'd0;

    if (last_i) begin
      cnt_d  = '0;
      pend_d = 1'b0;
    end else begin
      cnt_d  = cnt_mid + CNT_W'(e2);
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
    end else if (fire_i) begin
      accum_q <= last_i ? 32'd0 : accum_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* src/utp_out_fifo.sv */
// ----------------------------------------------------------------------------
// utp_out_fifo
// Result queue: takes up to three items per cycle, delivers one per cycle while the consumer is ready.
// ----------------------------------------------------------------------------
module utp_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  utp_pkg::utp_items_t items_i,
  output logic                space_o,
  output logic                valid_o,
  input  logic                ready_i,
  output utp_pkg::utp_item_t  item_o
);
  import utp_pkg::*;

  utp_item_t         mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [FCNT_W-1:0] cnt_q;
  logic              pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign space_o = (cnt_q <= FCNT_W'(FIFO_DEPTH - MAX_ITEMS));
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (2'(i) < items_i.n) begin
        mem_q[wr_q + PTR_W'(i)] <= items_i.item[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PTR_W'(items_i.n);
      rd_q  <= rd_q + PTR_W'(pop);
      cnt_q <= cnt_q + FCNT_W'(items_i.n) - FCNT_W'(pop);
    end
  end

endmodule

/* src/utf8_to_panel_charset.sv */
// Results are written into the result queue registers on a byte's transaction.
// Throughput: one byte per cycle while each byte yields at most one item and
// the consumer is ready; the output side delivers one item per cycle, so bytes
// yielding two or three items stall input while the four-entry queue drains.
// Reset clears the decode state, the result queue and the upper-case register.
// ----------------------------------------------------------------------------
// utf8_to_panel_charset
// Streaming UTF-8 to 8-bit panel charset converter with string terminator.
// ----------------------------------------------------------------------------
module utf8_to_panel_charset (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast    // out_end
);
  import utp_pkg::*;

  logic       upcase_q;
  logic       fire;
  utp_items_t items;
  utp_item_t  head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upcase_q <= 1'b0;
    end else if (cfg_we_i) begin
      upcase_q <= cfg_wdata_i;
    end
  end

  assign fire = s_axis_tvalid && s_axis_tready;

  utp_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .upcase_i (upcase_q),
    .items_o  (items)
  );

  utp_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .items_i (items),
    .space_o (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .item_o  (head)
  );

  assign m_axis_tdata = head.ch;
  assign m_axis_tlast = head.term;

endmodule
